>>> rtl/rpa_pkg.sv
// Package for the axis-angle rotation block: constants, types and the arctangent table.
package rpa_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CoordFracDef   = 16;
  localparam int AtanEntries    = 24;
  localparam int QueueDepth     = 4;

  // CORDIC datapath width (Q.28 plus headroom)
  localparam int CW = 34;

  localparam logic signed [CW-1:0] Q28Pi     = 34'sd843314857;
  localparam logic signed [CW-1:0] Q28HalfPi = 34'sd421657428;
  localparam logic signed [CW-1:0] Q28Gain   = 34'sd163008219;

  // arctangent of 2^-i in Q.28
  function automatic logic signed [CW-1:0] atan_q28(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 34'sd210828714;
      5'd1:  r = 34'sd124459457;
      5'd2:  r = 34'sd65760959;
      5'd3:  r = 34'sd33381290;
      5'd4:  r = 34'sd16755422;
      5'd5:  r = 34'sd8385879;
      5'd6:  r = 34'sd4193963;
      5'd7:  r = 34'sd2097109;
      5'd8:  r = 34'sd1048571;
      5'd9:  r = 34'sd524287;
      default: r = CW'(34'sd1) <<< (5'd28 - i);
    endcase
    return r;
  endfunction

  // item handed from the front to the back
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [32:0] dir_x;
    logic signed [32:0] dir_y;
    logic signed [32:0] dir_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [CW-1:0] z0;
    logic               flip;
  } work_t;

  typedef struct packed {
    logic signed [31:0] new_target_x;
    logic signed [31:0] new_target_y;
    logic signed [31:0] new_target_z;
  } result_t;

endpackage

>>> rtl/rpa_if.sv
// Valid/ready channel interfaces for the rotation block.
interface rpa_in_if (input logic clk_i);
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] turn_angle;
  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  axis_x, axis_y, axis_z, turn_angle, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                axis_x, axis_y, axis_z, turn_angle, output ready);
endinterface

interface rpa_out_if (input logic clk_i);
  logic               valid;
  logic               ready;
  logic signed [31:0] new_target_x;
  logic signed [31:0] new_target_y;
  logic signed [31:0] new_target_z;
  modport source (output valid, new_target_x, new_target_y, new_target_z, input ready);
  modport sink (input valid, new_target_x, new_target_y, new_target_z, output ready);
endinterface

>>> rtl/rotate_point_about_axis.sv
// Rotates a view target about an eye point around a unit axis (Rodrigues form).
// One item per cycle sustained while the output is not stalled. An accepted beat passes
// the front register, the queue and the unrolled CORDIC stages (CORDIC_STEPS, capped at
// 24), then six stages of rounding, products, matrix, multiply, sum and output. A four-entry
// queue sits between the front (direction and angle reduction) and the back, and a
// stalled output holds the whole back pipeline while the front keeps filling the queue.
// Coordinates are Q16.16, the angle Q3.13 radians, the axis Q2.14; results saturate.
module rotate_point_about_axis #(
  parameter int CORDIC_STEPS    = rpa_pkg::CordicStepsDef,
  parameter int COORD_FRAC_BITS = rpa_pkg::CoordFracDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  rpa_in_if.sink    in_i,
  rpa_out_if.source out_o
);
  // input and output share the coordinate format, so the fraction width only bounds-checks
  localparam bit FracOk = (COORD_FRAC_BITS >= 8) && (COORD_FRAC_BITS <= 24);

  logic           f_vld, q_wrdy, q_rvld, b_rdy;
  rpa_pkg::work_t f_work, q_work;

  rpa_front u_front (
    .clk_i, .rst_ni, .in_i, .vld_o(f_vld), .work_o(f_work), .rdy_i(q_wrdy)
  );

  rpa_queue #(.Depth(rpa_pkg::QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wvld_i(f_vld), .wrdy_o(q_wrdy), .wdata_i(f_work),
    .rvld_o(q_rvld), .rrdy_i(b_rdy), .rdata_o(q_work)
  );

  rpa_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .vld_i(q_rvld && FracOk), .rdy_o(b_rdy), .work_i(q_work), .out_o
  );

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.new_target_x))
    else $error("result changed while stalled");

  // front only advances into a queue with room
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_wrdy && f_vld |-> !in_i.ready)
    else $error("front accepted into full queue");
endmodule

>>> rtl/rpa_front.sv
// Front end: accepts beats, forms the direction and reduces the angle.
module rpa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpa_in_if.sink           in_i,
  output logic             vld_o,
  output rpa_pkg::work_t   work_o,
  input  logic             rdy_i
);
  logic             vld_q;
  rpa_pkg::work_t   work_q;
  rpa_pkg::work_t   work_d;
  logic signed [rpa_pkg::CW-1:0] z;

  assign in_i.ready = !vld_q || rdy_i;

  // classify angle quadrant and reduce by pi
  always_comb begin
    z = rpa_pkg::CW'(in_i.turn_angle) <<< 15;
    work_d.flip = 1'b0;
    work_d.z0   = z;
    if (z > rpa_pkg::Q28HalfPi) begin
      work_d.z0 = z - rpa_pkg::Q28Pi; work_d.flip = 1'b1;
    end else if (z < -rpa_pkg::Q28HalfPi) begin
      work_d.z0 = z + rpa_pkg::Q28Pi; work_d.flip = 1'b1;
    end
    work_d.eye_x  = in_i.eye_x;
    work_d.eye_y  = in_i.eye_y;
    work_d.eye_z  = in_i.eye_z;
    work_d.dir_x  = 33'(in_i.target_x) - 33'(in_i.eye_x);
    work_d.dir_y  = 33'(in_i.target_y) - 33'(in_i.eye_y);
    work_d.dir_z  = 33'(in_i.target_z) - 33'(in_i.eye_z);
    work_d.axis_x = in_i.axis_x;
    work_d.axis_y = in_i.axis_y;
    work_d.axis_z = in_i.axis_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (in_i.ready) vld_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) work_q <= work_d;
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;
endmodule

>>> rtl/rpa_queue.sv
// Short FIFO between front and back.
module rpa_queue #(
  parameter int Depth = rpa_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wvld_i,
  output logic           wrdy_o,
  input  rpa_pkg::work_t wdata_i,
  output logic           rvld_o,
  input  logic           rrdy_i,
  output rpa_pkg::work_t rdata_o
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  rpa_pkg::work_t   mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             wr, rd;

  assign wrdy_o  = cnt_q != (AW+1)'(Depth);
  assign rvld_o  = cnt_q != '0;
  assign wr      = wvld_i && wrdy_o;
  assign rd      = rvld_o && rrdy_i;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wdata_i;
  end
endmodule

>>> rtl/rpa_back.sv
// Back end: pipelined CORDIC, matrix build, matrix-vector product, saturation.
module rpa_back #(
  parameter int CordicSteps = rpa_pkg::CordicStepsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  rpa_pkg::work_t work_i,
  rpa_out_if.source      out_o
);
  localparam int CW = rpa_pkg::CW;
  localparam int NS = (CordicSteps < rpa_pkg::AtanEntries) ? CordicSteps
                                                           : rpa_pkg::AtanEntries;
  // stages: NS cordic, round, products, matrix, mul, sum, out
  localparam int NP = NS + 6;

  logic adv;
  logic [NP-1:0] v_q;
  assign adv   = !out_o.valid || out_o.ready;
  assign rdy_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NP-2:0], vld_i};
  end
  assign out_o.valid = v_q[NP-1];

  // CORDIC stages; the first one starts from the queue output
  logic signed [CW-1:0] cx_q [1:NS];
  logic signed [CW-1:0] cy_q [1:NS];
  logic signed [CW-1:0] cz_q [1:NS];
  rpa_pkg::work_t       w_q  [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CW-1:0] xi, yi, zi, dx, dy;
    rpa_pkg::work_t       wi;
    if (i == 0) begin : g_first
      assign xi = rpa_pkg::Q28Gain;
      assign yi = '0;
      assign zi = work_i.z0;
      assign wi = work_i;
    end else begin : g_next
      assign xi = cx_q[i];
      assign yi = cy_q[i];
      assign zi = cz_q[i];
      assign wi = w_q[i];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        w_q[i+1] <= wi;
        if (zi >= 0) begin
          cx_q[i+1] <= xi - dx;
          cy_q[i+1] <= yi + dy;
          cz_q[i+1] <= zi - rpa_pkg::atan_q28(5'(i));
        end else begin
          cx_q[i+1] <= xi + dx;
          cy_q[i+1] <= yi - dy;
          cz_q[i+1] <= zi + rpa_pkg::atan_q28(5'(i));
        end
      end
    end
  end

  // round sin/cos to Q.14 and clamp
  function automatic logic signed [15:0] rnd14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(8192)) >>> 14;
    if (r > CW'(16384)) return 16'sd16384;
    if (r < -CW'(16384)) return -16'sd16384;
    return r[15:0];
  endfunction

  logic signed [CW-1:0] fx, fy;
  assign fx = w_q[NS].flip ? -cx_q[NS] : cx_q[NS];
  assign fy = w_q[NS].flip ? -cy_q[NS] : cy_q[NS];

  // 1 - cos reaches 2.0 at an angle of pi, so it needs 17 bits
  logic signed [15:0] s_q, c_q;
  logic signed [16:0] t_q;
  rpa_pkg::work_t     wr_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q  <= rnd14(fy);
      c_q  <= rnd14(fx);
      t_q  <= 17'sd16384 - 17'(rnd14(fx));
      wr_q <= w_q[NS];
    end
  end

  // axis products: a_i*a_j (Q.28), s*a_i (Q.28)
  logic signed [31:0] aa_q [6];
  logic signed [31:0] sa_q [3];
  logic signed [16:0] t2_q;
  logic signed [15:0] c2_q;
  rpa_pkg::work_t     wp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      aa_q[0] <= 32'(wr_q.axis_x * wr_q.axis_x);
      aa_q[1] <= 32'(wr_q.axis_x * wr_q.axis_y);
      aa_q[2] <= 32'(wr_q.axis_x * wr_q.axis_z);
      aa_q[3] <= 32'(wr_q.axis_y * wr_q.axis_y);
      aa_q[4] <= 32'(wr_q.axis_y * wr_q.axis_z);
      aa_q[5] <= 32'(wr_q.axis_z * wr_q.axis_z);
      sa_q[0] <= 32'(s_q * wr_q.axis_x);
      sa_q[1] <= 32'(s_q * wr_q.axis_y);
      sa_q[2] <= 32'(s_q * wr_q.axis_z);
      t2_q <= t_q;
      c2_q <= c_q;
      wp_q <= wr_q;
    end
  end

  // matrix entries in Q.42 rounded to Q.24
  function automatic logic signed [27:0] q24(input logic signed [51:0] m);
    logic signed [51:0] r;
    r = (m + 52'sd131072) >>> 18;
    return r[27:0];
  endfunction

  logic signed [51:0] ta [6];
  logic signed [51:0] sk [3];
  logic signed [51:0] c42;
  always_comb begin
    for (int k = 0; k < 6; k++) ta[k] = 52'(t2_q) * 52'(aa_q[k]);
    for (int k = 0; k < 3; k++) sk[k] = 52'(sa_q[k]) <<< 14;
    c42 = 52'(c2_q) <<< 28;
  end

  logic signed [27:0] m_q [9];
  rpa_pkg::work_t     wm_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q[0] <= q24(c42 + ta[0]);
      m_q[1] <= q24(ta[1] - sk[2]);
      m_q[2] <= q24(ta[2] + sk[1]);
      m_q[3] <= q24(ta[1] + sk[2]);
      m_q[4] <= q24(c42 + ta[3]);
      m_q[5] <= q24(ta[4] - sk[0]);
      m_q[6] <= q24(ta[2] - sk[1]);
      m_q[7] <= q24(ta[4] + sk[0]);
      m_q[8] <= q24(c42 + ta[5]);
      wm_q <= wp_q;
    end
  end

  // matrix times direction, one product per entry
  logic signed [60:0] p_q [9];
  rpa_pkg::work_t     wu_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p_q[3*r]   <= 61'(m_q[3*r])   * 61'(wm_q.dir_x);
        p_q[3*r+1] <= 61'(m_q[3*r+1]) * 61'(wm_q.dir_y);
        p_q[3*r+2] <= 61'(m_q[3*r+2]) * 61'(wm_q.dir_z);
      end
      wu_q <= wm_q;
    end
  end

  // row sums, round to Q16.16, add eye
  logic signed [63:0] acc [3];
  logic signed [63:0] sm_d [3];
  logic signed [31:0] eye [3];
  assign eye[0] = wu_q.eye_x;
  assign eye[1] = wu_q.eye_y;
  assign eye[2] = wu_q.eye_z;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r]  = 64'(p_q[3*r]) + 64'(p_q[3*r+1]) + 64'(p_q[3*r+2]);
      sm_d[r] = ((acc[r] + 64'sd8388608) >>> 24) + 64'(eye[r]);
    end
  end

  logic signed [63:0] sm_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) for (int r = 0; r < 3; r++) sm_q[r] <= sm_d[r];
  end

  // saturate into the output register
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  rpa_pkg::result_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.new_target_x <= sat32(sm_q[0]);
      res_q.new_target_y <= sat32(sm_q[1]);
      res_q.new_target_z <= sat32(sm_q[2]);
    end
  end
  assign out_o.new_target_x = res_q.new_target_x;
  assign out_o.new_target_y = res_q.new_target_y;
  assign out_o.new_target_z = res_q.new_target_z;
endmodule
